// File: src/rlt_pkg.sv
`default_nettype none

package rlt_pkg;

  // Operation codes
  localparam logic [1:0] OpPrepare = 2'd0;
  localparam logic [1:0] OpObserve = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  localparam int unsigned MsPerS = 1000;
  localparam logic [63:0] Limit64 = 64'hFFFF_FFFF_FFFF_FFFF;
  // Largest lease in seconds whose millisecond length still fits 64 bits
  localparam logic [63:0] LeaseMax = Limit64 / 64'(MsPerS);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] entry_key;
    logic        refresh;
    logic [63:0] wall_seconds;
    logic [63:0] steady_millis;
    logic [63:0] lease_seconds;
    logic [63:0] result_revision;
    logic        result_expired;
    logic        result_succeeded;
    logic [63:0] result_expiry;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] granted_revision;
    logic        standby_ok;
    logic [31:0] expired_count;
    logic [31:0] late_count;
  } out_t;

  // Seconds to milliseconds: x * 1000 = (x << 10) - (x << 4) - (x << 3)
  function automatic logic [63:0] to_millis(logic [63:0] secs);
    return (secs << 10) - (secs << 4) - (secs << 3);
  endfunction

endpackage

`default_nettype wire

// File: src/rlt_core.sv
`default_nettype none

module rlt_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [63:0]   cfg_floor_i,
  input  wire logic          go_i,
  input  wire rlt_pkg::in_t  item_i,
  output rlt_pkg::out_t      result_o
);

  logic [63:0] high_water_q, high_water_d;
  logic [63:0] cur_rev_q, cur_rev_d;
  logic [63:0] cur_key_q, cur_key_d;
  logic        pending_q, pending_d;
  logic [63:0] start_q, start_d;
  logic [63:0] lease_ms_q, lease_ms_d;
  logic [63:0] expiry_q, expiry_d;
  logic [63:0] good_expiry_q, good_expiry_d;
  logic [63:0] good_start_q, good_start_d;
  logic [63:0] good_lease_q, good_lease_d;
  logic [31:0] expired_q, expired_d;
  logic [31:0] late_q, late_d;

  logic        is_prep, is_obs, is_clr;
  logic        rev_nz, steady_ok, cur_alive, good_alive, pend_alive;
  logic        retire, reuse, refuse, issue;
  logic        match, obs_drop, adopt, succ;
  logic        eff_exp_gt;
  logic [64:0] exp_sum;
  logic [63:0] next_rev;
  logic        standby;

  assign is_prep = item_i.op == rlt_pkg::OpPrepare;
  assign is_obs  = item_i.op == rlt_pkg::OpObserve;
  assign is_clr  = item_i.op == rlt_pkg::OpClear;

  // Lease checks against the stored state, all in parallel
  assign rev_nz     = cur_rev_q != '0;
  assign steady_ok  = (item_i.steady_millis >= start_q) &&
                      ((item_i.steady_millis - start_q) < lease_ms_q);
  assign cur_alive  = (expiry_q > item_i.wall_seconds) && steady_ok;
  assign good_alive = (good_expiry_q > item_i.wall_seconds) &&
                      (item_i.steady_millis >= good_start_q) &&
                      ((item_i.steady_millis - good_start_q) < good_lease_q);
  assign pend_alive = pending_q && rev_nz && cur_alive;

  // Prepare decisions
  assign retire  = is_prep && rev_nz && !cur_alive;
  assign reuse   = rev_nz && !retire && (item_i.entry_key == cur_key_q) &&
                   (pending_q || !item_i.refresh);
  assign exp_sum = {1'b0, item_i.wall_seconds} + {1'b0, item_i.lease_seconds};
  assign refuse  = (high_water_q == rlt_pkg::Limit64) || (item_i.lease_seconds == '0) ||
                   (item_i.lease_seconds > rlt_pkg::LeaseMax) || exp_sum[64];
  assign issue   = is_prep && !reuse && !refuse;
  assign next_rev = high_water_q + 64'd1;

  // Observe decisions
  assign match      = is_obs && (item_i.result_revision != '0) &&
                      (item_i.result_revision == cur_rev_q);
  assign obs_drop   = match && item_i.result_expired;
  assign adopt      = match && !item_i.result_expired && (item_i.result_expiry != '0);
  assign succ       = match && !item_i.result_expired && item_i.result_succeeded;
  assign eff_exp_gt = adopt ? (item_i.result_expiry > item_i.wall_seconds)
                            : (expiry_q > item_i.wall_seconds);

  // Next state
  always_comb begin
    high_water_d  = high_water_q;
    cur_rev_d     = cur_rev_q;
    cur_key_d     = cur_key_q;
    pending_d     = pending_q;
    start_d       = start_q;
    lease_ms_d    = lease_ms_q;
    expiry_d      = expiry_q;
    good_expiry_d = good_expiry_q;
    good_start_d  = good_start_q;
    good_lease_d  = good_lease_q;
    expired_d     = expired_q;
    late_d        = late_q;
    if (is_prep) begin
      if (retire) begin
        expired_d = expired_q + 32'd1;
        cur_rev_d = '0;
        cur_key_d = '0;
        pending_d = 1'b0;
      end
      if (issue) begin
        high_water_d = next_rev;
        cur_rev_d    = next_rev;
        cur_key_d    = item_i.entry_key;
        start_d      = item_i.steady_millis;
        lease_ms_d   = rlt_pkg::to_millis(item_i.lease_seconds);
        expiry_d     = exp_sum[63:0];
        pending_d    = 1'b1;
      end
    end else if (is_obs) begin
      if (!match) begin
        late_d = late_q + 32'd1;
      end else if (obs_drop) begin
        expired_d = expired_q + 32'd1;
        cur_rev_d = '0;
        cur_key_d = '0;
        pending_d = 1'b0;
      end else begin
        if (adopt) begin
          expiry_d = item_i.result_expiry;
        end
        if (succ) begin
          pending_d     = 1'b0;
          good_expiry_d = adopt ? item_i.result_expiry : expiry_q;
          good_start_d  = start_q;
          good_lease_d  = lease_ms_q;
        end
      end
    end else if (is_clr) begin
      cur_key_d     = '0;
      cur_rev_d     = '0;
      expiry_d      = '0;
      good_expiry_d = '0;
      pending_d     = 1'b0;
    end
  end

  // Standby viability after the step, picked from the parallel checks
  always_comb begin
    standby = good_alive || pend_alive;
    if (is_prep) begin
      standby = good_alive || issue || pend_alive;
    end else if (is_obs) begin
      if (obs_drop) begin
        standby = good_alive;
      end else if (match) begin
        // good lease becomes the current one on success
        standby = (succ ? 1'b0 : good_alive) ||
                  (eff_exp_gt && steady_ok &&
                   (succ || (pending_q && !item_i.result_succeeded)));
      end
    end else if (is_clr) begin
      standby = 1'b0;
    end
  end

  // Result
  always_comb begin
    result_o.accepted         = (is_prep && (reuse || issue)) || match || is_clr;
    result_o.granted_revision = issue ? next_rev : ((is_prep && reuse) ? cur_rev_q : '0);
    result_o.standby_ok       = standby;
    result_o.expired_count    = expired_d;
    result_o.late_count       = late_d;
  end

  // State registers; a configuration write loads the high-water mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_water_q  <= '0;
      cur_rev_q     <= '0;
      cur_key_q     <= '0;
      pending_q     <= 1'b0;
      start_q       <= '0;
      lease_ms_q    <= '0;
      expiry_q      <= '0;
      good_expiry_q <= '0;
      good_start_q  <= '0;
      good_lease_q  <= '0;
      expired_q     <= '0;
      late_q        <= '0;
    end else if (cfg_we_i) begin
      high_water_q <= cfg_floor_i;
    end else if (go_i) begin
      high_water_q  <= high_water_d;
      cur_rev_q     <= cur_rev_d;
      cur_key_q     <= cur_key_d;
      pending_q     <= pending_d;
      start_q       <= start_d;
      lease_ms_q    <= lease_ms_d;
      expiry_q      <= expiry_d;
      good_expiry_q <= good_expiry_d;
      good_start_q  <= good_start_d;
      good_lease_q  <= good_lease_d;
      expired_q     <= expired_d;
      late_q        <= late_d;
    end
  end

endmodule

`default_nettype wire

// File: src/revisioned_lease_tracker.sv
// Flow: an accepted transfer is held in the input register, and its result is
// registered in the result register once that is free; out_valid_o then rises.
// Throughput: one item per cycle while the output is not stalled; the tracker state
// is updated by combinational logic between the input register and the result register.
// Reset: asynchronous, active low; clears the valid flags, all tracker state, counters and the high-water mark.
`default_nettype none

module revisioned_lease_tracker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [63:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rlt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rlt_pkg::out_t      out_data_o
);

  logic          in_valid_q;
  rlt_pkg::in_t  in_q;
  logic          out_valid_q;
  rlt_pkg::out_t out_q;
  rlt_pkg::out_t result;
  logic          go;
  logic          cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Process the held item whenever the result register can take it
  assign go         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || go;

  rlt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_floor_i (cfg_data_i),
    .go_i        (go),
    .item_i      (in_q),
    .result_o    (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
